// File: rtl/mge_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the mouse gesture event generator.
// No dependencies; used by every module of the block.
package mge_pkg;

   localparam int COORD_WIDTH  = 12;
   localparam int DELTA_WIDTH  = COORD_WIDTH + 1;
   localparam int BUTTON_COUNT = 3;
   localparam int MOD_WIDTH    = 3;
   localparam int TICK_WIDTH   = 32;
   localparam int WINDOW_WIDTH = 16;
   localparam int KIND_WIDTH   = 3;

   localparam int REQ_DATA_WIDTH = 64;
   localparam int RSP_DATA_WIDTH = 64;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = WINDOW_WIDTH;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);

   localparam logic [KIND_WIDTH-1:0] KIND_MOVE   = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_DOWN   = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_UP     = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_CLICK  = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_DOUBLE = 3'd4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW   = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISTANCE = 1'd1;

   localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET   = 16'd500;
   localparam logic [COORD_WIDTH-1:0]  DISTANCE_RESET = 12'd5;

   typedef logic [COORD_WIDTH-1:0]  coord_type;
   typedef logic [DELTA_WIDTH-1:0]  delta_type;
   typedef logic [BUTTON_COUNT-1:0] buttons_type;
   typedef logic [MOD_WIDTH-1:0]    mods_type;
   typedef logic [TICK_WIDTH-1:0]   tick_type;

   typedef struct packed {
      coord_type   x;
      coord_type   y;
      delta_type   dx;
      delta_type   dy;
      logic        move;
      buttons_type changed;
      buttons_type btns;
      mods_type    mods;
      tick_type    now;
   } entry_type;

endpackage

// File: rtl/mouse_gesture_event_generator.sv
`timescale 1ns / 1ps
// Mouse gesture event generator: turns mouse samples into move, button and click events.
// The first event of a sample is offered after the queue, the back end's sample register and the output register.
// The back end gives one event beat per cycle while the response output is not stalled.
// A four-entry queue lets the front end take a sample each cycle, while the queue is not full, as the back end works.
// Synchronous reset clears position, button and click state and loads register defaults.
module mouse_gesture_event_generator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // present, x, y, buttons, modifiers, ticks (from bit 0 up), zero pad to 64
   input  logic [mge_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // x, y, delta x, delta y, button, buttons now, modifiers (from bit 0 up), zero pad
   output logic [mge_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // event kind
   output logic [mge_pkg::KIND_WIDTH-1:0]      rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [mge_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mge_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic [mge_pkg::WINDOW_WIDTH-1:0] window_ff;
   mge_pkg::coord_type               distance_ff;

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_valid;
   mge_pkg::entry_type push_entry;
   mge_pkg::entry_type head_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= mge_pkg::WINDOW_RESET;
         distance_ff <= mge_pkg::DISTANCE_RESET;
      end else if (csr_we) begin
         if (csr_index == mge_pkg::CSR_WINDOW) begin
            window_ff <= csr_wdata[mge_pkg::WINDOW_WIDTH-1:0];
         end
         if (csr_index == mge_pkg::CSR_DISTANCE) begin
            distance_ff <= csr_wdata[mge_pkg::COORD_WIDTH-1:0];
         end
      end
   end

   mge_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   mge_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   mge_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (head_entry),
      .q_pop      (q_pop),
      .window     (window_ff),
      .distance   (distance_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A click or a double-click is always followed by an up event of the same sample.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == mge_pkg::KIND_CLICK || rsp_tuser == mge_pkg::KIND_DOUBLE)
      |-> !rsp_tlast)
      else $error("click event marked as last of its sample");

   // Only move events carry deltas and they name no button.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == mge_pkg::KIND_MOVE |-> rsp_tdata[52:50] == '0)
      else $error("move event names a button");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != mge_pkg::KIND_MOVE
      |-> rsp_tdata[49:24] == '0 && $onehot(rsp_tdata[52:50]))
      else $error("button event with deltas or without a single button");

   // The queue never takes a sample while full.
   assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("sample pushed into a full queue");

endmodule

// File: rtl/mge_front.sv
`timescale 1ns / 1ps
// Front end: accepts mouse samples, tracks position and buttons, and queues work.
// Depends on mge_pkg.
module mge_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // present, x, y, buttons, modifiers, ticks (from bit 0 up), zero pad to 64
   input  logic [mge_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic                               q_full,
   output logic                               q_push,
   output mge_pkg::entry_type                 q_entry
);

   mge_pkg::coord_type   last_x_ff, last_x_in;
   mge_pkg::coord_type   last_y_ff, last_y_in;
   mge_pkg::buttons_type last_btns_ff, last_btns_in;

   logic                 present;
   logic                 accept;
   mge_pkg::coord_type   x;
   mge_pkg::coord_type   y;
   mge_pkg::buttons_type btns;

   assign present = req_tdata[0];
   assign x       = req_tdata[12:1];
   assign y       = req_tdata[24:13];
   assign btns    = req_tdata[27:25];

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      q_entry.x       = x;
      q_entry.y       = y;
      q_entry.dx      = {1'b0, x} - {1'b0, last_x_ff};
      q_entry.dy      = {1'b0, y} - {1'b0, last_y_ff};
      q_entry.move    = (x != last_x_ff) || (y != last_y_ff);
      q_entry.changed = btns ^ last_btns_ff;
      q_entry.btns    = btns;
      q_entry.mods    = req_tdata[30:28];
      q_entry.now     = req_tdata[62:31];
      q_push = accept && present && (q_entry.move || (q_entry.changed != '0));
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      last_btns_in = last_btns_ff;
      if (accept && present) begin
         last_x_in    = x;
         last_y_in    = y;
         last_btns_in = btns;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         last_btns_ff <= '0;
      end else begin
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         last_btns_ff <= last_btns_in;
      end
   end

endmodule

// File: rtl/mge_queue.sv
`timescale 1ns / 1ps
// Short queue of sample work between the front end and the event back end.
// Depends on mge_pkg.
module mge_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mge_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output mge_pkg::entry_type head_entry
);

   mge_pkg::entry_type                 slot_ff [mge_pkg::QUEUE_DEPTH];
   logic [mge_pkg::QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mge_pkg::QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mge_pkg::QUEUE_PTR_WIDTH:0]   count_ff, count_in;

   assign full       = count_ff == (mge_pkg::QUEUE_PTR_WIDTH + 1)'(mge_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/mge_back.sv
`timescale 1ns / 1ps
// Back end: walks one queued sample per run, one event per beat, and keeps the click state.
// Depends on mge_pkg.
module mge_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  mge_pkg::entry_type                 q_entry,
   output logic                               q_pop,
   input  logic [mge_pkg::WINDOW_WIDTH-1:0]   window,
   input  mge_pkg::coord_type                 distance,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // x, y, delta x, delta y, button, buttons now, modifiers (from bit 0 up), zero pad
   output logic [mge_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // event kind
   output logic [mge_pkg::KIND_WIDTH-1:0]     rsp_tuser,
   output logic                               rsp_tlast
);

   localparam logic [1:0] SUB_CLICK  = 2'd0;
   localparam logic [1:0] SUB_DOUBLE = 2'd1;
   localparam logic [1:0] SUB_UP     = 2'd2;

   function automatic mge_pkg::coord_type abs_diff(mge_pkg::coord_type a, mge_pkg::coord_type b);
      abs_diff = (a >= b) ? a - b : b - a;
   endfunction

   mge_pkg::entry_type   cur_ff;
   logic                 busy_ff, busy_in;
   logic                 move_pend_ff, move_pend_in;
   mge_pkg::buttons_type rem_ff, rem_in;
   logic [1:0]           sub_ff, sub_in;
   mge_pkg::tick_type    click_time_ff, click_time_in;
   mge_pkg::coord_type   click_x_ff, click_x_in;
   mge_pkg::coord_type   click_y_ff, click_y_in;
   logic                 out_valid_ff;
   logic [mge_pkg::RSP_DATA_WIDTH-1:0] out_data_ff;
   logic [mge_pkg::KIND_WIDTH-1:0]     out_kind_ff;
   logic                 out_last_ff;

   logic                          adv;
   logic                          emit;
   logic                          done;
   logic                          load;
   mge_pkg::buttons_type          btn_bit;
   mge_pkg::buttons_type          rest;
   logic                          pressed;
   logic                          dbl_hit;
   mge_pkg::tick_type             elapsed;
   logic [mge_pkg::KIND_WIDTH-1:0] ev_kind;
   mge_pkg::buttons_type          ev_mask;
   mge_pkg::delta_type            ev_dx;
   mge_pkg::delta_type            ev_dy;
   logic                          ev_last;

   assign adv     = !out_valid_ff || rsp_tready;
   assign emit    = busy_ff && adv;
   assign done    = emit && ev_last;
   assign load    = q_valid && (!busy_ff || done);
   assign q_pop   = load;
   assign btn_bit = rem_ff & (~rem_ff + 1'b1);
   assign rest    = rem_ff & ~btn_bit;
   assign pressed = (cur_ff.btns & btn_bit) != '0;
   assign elapsed = cur_ff.now - click_time_ff;
   assign dbl_hit = (elapsed < {{(mge_pkg::TICK_WIDTH - mge_pkg::WINDOW_WIDTH){1'b0}}, window})
                    && (abs_diff(cur_ff.x, click_x_ff) < distance)
                    && (abs_diff(cur_ff.y, click_y_ff) < distance);

   always_comb begin
      ev_kind       = mge_pkg::KIND_UP;
      ev_mask       = btn_bit;
      ev_dx         = '0;
      ev_dy         = '0;
      ev_last       = 1'b0;
      move_pend_in  = move_pend_ff;
      rem_in        = rem_ff;
      sub_in        = sub_ff;
      click_time_in = click_time_ff;
      click_x_in    = click_x_ff;
      click_y_in    = click_y_ff;
      if (move_pend_ff) begin
         ev_kind      = mge_pkg::KIND_MOVE;
         ev_mask      = '0;
         ev_dx        = cur_ff.dx;
         ev_dy        = cur_ff.dy;
         ev_last      = rem_ff == '0;
         move_pend_in = 1'b0;
      end else if (pressed) begin
         ev_kind = mge_pkg::KIND_DOWN;
         ev_last = rest == '0;
         rem_in  = rest;
      end else begin
         unique case (sub_ff)
            SUB_CLICK: begin
               ev_kind = mge_pkg::KIND_CLICK;
               if (dbl_hit) begin
                  click_time_in = '0;
                  sub_in        = SUB_DOUBLE;
               end else begin
                  click_time_in = cur_ff.now;
                  click_x_in    = cur_ff.x;
                  click_y_in    = cur_ff.y;
                  sub_in        = SUB_UP;
               end
            end
            SUB_DOUBLE: begin
               ev_kind = mge_pkg::KIND_DOUBLE;
               sub_in  = SUB_UP;
            end
            SUB_UP: begin
               ev_kind = mge_pkg::KIND_UP;
               ev_last = rest == '0;
               rem_in  = rest;
               sub_in  = SUB_CLICK;
            end
            default: begin
               sub_in = SUB_CLICK;
            end
         endcase
      end
      busy_in = busy_ff;
      if (load) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         move_pend_ff  <= 1'b0;
         rem_ff        <= '0;
         sub_ff        <= SUB_CLICK;
         click_time_ff <= '0;
         click_x_ff    <= '0;
         click_y_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (emit) begin
            move_pend_ff  <= move_pend_in;
            rem_ff        <= rem_in;
            sub_ff        <= sub_in;
            click_time_ff <= click_time_in;
            click_x_ff    <= click_x_in;
            click_y_ff    <= click_y_in;
         end
         if (load) begin
            move_pend_ff <= q_entry.move;
            rem_ff       <= q_entry.changed;
            sub_ff       <= SUB_CLICK;
         end
         if (adv) begin
            out_valid_ff <= busy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= q_entry;
      end
      if (emit) begin
         out_data_ff <= {5'b0, cur_ff.mods, cur_ff.btns, ev_mask, ev_dy, ev_dx,
                         cur_ff.y, cur_ff.x};
         out_kind_ff <= ev_kind;
         out_last_ff <= ev_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// File: sim/tb_mouse_gesture_event_generator.sv
`timescale 1ns / 1ps
// Self-checking testbench for the mouse gesture event generator: drives mouse samples,
// predicts the pointer events and compares every result beat.
// Depends on mge_pkg and the mouse_gesture_event_generator module.
module tb_mouse_gesture_event_generator;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int HOLD_CYCLES    = 300;

   typedef struct packed {
      logic                 present;
      mge_pkg::coord_type   x;
      mge_pkg::coord_type   y;
      mge_pkg::buttons_type btns;
      mge_pkg::mods_type    mods;
      mge_pkg::tick_type    tick;
   } mouse_sample_type;

   typedef struct packed {
      logic [mge_pkg::KIND_WIDTH-1:0] kind;
      mge_pkg::coord_type             x;
      mge_pkg::coord_type             y;
      mge_pkg::delta_type             dx;
      mge_pkg::delta_type             dy;
      mge_pkg::buttons_type           btn;
      mge_pkg::buttons_type           btns;
      mge_pkg::mods_type              mods;
      logic                           last;
   } pointer_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [mge_pkg::REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [mge_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [mge_pkg::KIND_WIDTH-1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [mge_pkg::CSR_INDEX_WIDTH-1:0] csr_index = mge_pkg::CSR_WINDOW;
   logic [mge_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   mouse_gesture_event_generator dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   mouse_sample_type samples_to_send[$];
   pointer_event_type events_due[$];
   mouse_sample_type offered;

   // Predicted block state and registers.
   mge_pkg::coord_type seen_x = '0;
   mge_pkg::coord_type seen_y = '0;
   mge_pkg::buttons_type seen_btns = '0;
   mge_pkg::tick_type click_tick = '0;
   mge_pkg::coord_type click_x = '0;
   mge_pkg::coord_type click_y = '0;
   logic [mge_pkg::WINDOW_WIDTH-1:0] dbl_window = mge_pkg::WINDOW_RESET;
   mge_pkg::coord_type dbl_distance = mge_pkg::DISTANCE_RESET;

   // Sample generator tracking.
   mge_pkg::coord_type gen_x = '0;
   mge_pkg::coord_type gen_y = '0;
   mge_pkg::buttons_type gen_btns = '0;
   mge_pkg::tick_type gen_tick = '0;

   int queued_total = 0;
   int present_queued = 0;
   int accepted_total = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   function automatic mge_pkg::coord_type coord_gap(mge_pkg::coord_type a,
                                                     mge_pkg::coord_type b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic mge_pkg::coord_type near(mge_pkg::coord_type c, int spread);
      int v;
      v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return mge_pkg::coord_type'(v);
   endfunction

   function automatic string fmt_event(pointer_event_type e);
      return $sformatf("kind %0d x %0d y %0d dx %0d dy %0d btn %0d btns %0d mods %0d last %0d",
                       e.kind, e.x, e.y, $signed(e.dx), $signed(e.dy), e.btn, e.btns,
                       e.mods, e.last);
   endfunction

   task automatic predict_events(mouse_sample_type s);
      pointer_event_type run[$];
      pointer_event_type ev;
      mge_pkg::tick_type elapsed;
      if (!s.present) return;
      ev = '0;
      ev.x = s.x;
      ev.y = s.y;
      ev.btns = s.btns;
      ev.mods = s.mods;
      if (s.x != seen_x || s.y != seen_y) begin
         ev.kind = mge_pkg::KIND_MOVE;
         ev.dx = mge_pkg::delta_type'(s.x) - mge_pkg::delta_type'(seen_x);
         ev.dy = mge_pkg::delta_type'(s.y) - mge_pkg::delta_type'(seen_y);
         run.push_back(ev);
         seen_x = s.x;
         seen_y = s.y;
      end
      ev.dx = '0;
      ev.dy = '0;
      for (int b = 0; b < mge_pkg::BUTTON_COUNT; b++) begin
         if (s.btns[b] != seen_btns[b]) begin
            ev.btn = mge_pkg::buttons_type'(1) << b;
            if (s.btns[b]) begin
               ev.kind = mge_pkg::KIND_DOWN;
               run.push_back(ev);
            end else begin
               ev.kind = mge_pkg::KIND_CLICK;
               run.push_back(ev);
               elapsed = s.tick - click_tick;
               if (elapsed < mge_pkg::tick_type'(dbl_window)
                   && coord_gap(s.x, click_x) < dbl_distance
                   && coord_gap(s.y, click_y) < dbl_distance) begin
                  ev.kind = mge_pkg::KIND_DOUBLE;
                  run.push_back(ev);
                  click_tick = '0;
               end else begin
                  click_tick = s.tick;
                  click_x = s.x;
                  click_y = s.y;
               end
               ev.kind = mge_pkg::KIND_UP;
               run.push_back(ev);
            end
         end
      end
      seen_btns = s.btns;
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      foreach (run[i]) events_due.push_back(run[i]);
   endtask

   task automatic check_event();
      pointer_event_type got;
      pointer_event_type want;
      got.kind = rsp_tuser;
      got.x = rsp_tdata[11:0];
      got.y = rsp_tdata[23:12];
      got.dx = rsp_tdata[36:24];
      got.dy = rsp_tdata[49:37];
      got.btn = rsp_tdata[52:50];
      got.btns = rsp_tdata[55:53];
      got.mods = rsp_tdata[58:56];
      got.last = rsp_tlast;
      if (events_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected event beat: %s", fmt_event(got));
      end else begin
         want = events_due.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("event mismatch\n  expected: %s\n  actual:   %s",
                        fmt_event(want), fmt_event(got));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_events(offered);
            accepted_total++;
         end
         if (!req_tvalid || req_tready) begin
            if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = samples_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {1'b0, offered.tick, offered.mods, offered.btns,
                             offered.y, offered.x, offered.present};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_event();
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_sample(logic present, mge_pkg::coord_type x, mge_pkg::coord_type y,
                             mge_pkg::buttons_type btns, mge_pkg::mods_type mods,
                             mge_pkg::tick_type tick);
      mouse_sample_type s;
      s = '{present, x, y, btns, mods, tick};
      samples_to_send.push_back(s);
      queued_total++;
      if (present) begin
         present_queued++;
         gen_x = x;
         gen_y = y;
         gen_btns = btns;
         gen_tick = tick;
      end
   endtask

   task automatic add_gesture();
      int pick;
      int spread;
      int span;
      mge_pkg::buttons_type m;
      spread = 2 * int'(dbl_distance) + 1;
      span = 2 * int'(dbl_window) + 2;
      pick = $urandom_range(9);
      if (pick == 0) begin
         add_sample($urandom_range(9) != 0, mge_pkg::coord_type'($urandom),
                    mge_pkg::coord_type'($urandom), mge_pkg::buttons_type'($urandom),
                    mge_pkg::mods_type'($urandom), mge_pkg::tick_type'($urandom));
      end else if (pick == 1) begin
         add_sample(1'b0, mge_pkg::coord_type'($urandom), mge_pkg::coord_type'($urandom),
                    mge_pkg::buttons_type'($urandom), mge_pkg::mods_type'($urandom),
                    mge_pkg::tick_type'($urandom));
      end else if (pick <= 3) begin
         add_sample(1'b1,
                    $urandom_range(1) ? near(gen_x, 64) : mge_pkg::coord_type'($urandom),
                    $urandom_range(1) ? near(gen_y, 64) : mge_pkg::coord_type'($urandom),
                    gen_btns, mge_pkg::mods_type'($urandom),
                    gen_tick + $urandom_range(0, span));
      end else begin
         m = mge_pkg::buttons_type'($urandom_range(1, 7));
         repeat ($urandom_range(1, 2)) begin
            add_sample(1'b1, near(gen_x, spread), near(gen_y, spread), gen_btns | m,
                       mge_pkg::mods_type'($urandom), gen_tick + $urandom_range(0, span));
            add_sample(1'b1, near(gen_x, spread), near(gen_y, spread), gen_btns & ~m,
                       mge_pkg::mods_type'($urandom), gen_tick + $urandom_range(0, span));
         end
      end
   endtask

   task automatic write_csr(logic [mge_pkg::CSR_INDEX_WIDTH-1:0] index,
                            logic [mge_pkg::CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      if (index == mge_pkg::CSR_WINDOW) dbl_window = data;
      else dbl_distance = data[mge_pkg::COORD_WIDTH-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic settle();
      while (accepted_total != queued_total || events_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(logic [mge_pkg::CSR_DATA_WIDTH-1:0] window,
                            logic [mge_pkg::CSR_DATA_WIDTH-1:0] distance,
                            int count, int send_pct, int recv_pct, bit hold);
      int target;
      settle();
      write_csr(mge_pkg::CSR_WINDOW, window);
      write_csr(mge_pkg::CSR_DISTANCE, distance);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      gen_tick = $urandom;
      target = present_queued + count;
      while (present_queued < target) add_gesture();
      if (hold) hold_requests++;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed samples with the reset register values.
      add_sample(1'b0, 12'd4095, 12'd4095, 3'd7, 3'd7, 32'hFFFF_FFFF);
      add_sample(1'b1, 12'd0, 12'd0, 3'd0, 3'd0, 32'd0);
      add_sample(1'b1, 12'd4095, 12'd4095, 3'd0, 3'd7, 32'd1);
      add_sample(1'b1, 12'd0, 12'd0, 3'd0, 3'd0, 32'd2);
      add_sample(1'b1, 12'd1, 12'd1, 3'd7, 3'd5, 32'd5);
      add_sample(1'b1, 12'd2, 12'd2, 3'd0, 3'd2, 32'd6);
      add_sample(1'b1, 12'd300, 12'd300, 3'd2, 3'd1, 32'd2000);
      add_sample(1'b1, 12'd300, 12'd300, 3'd0, 3'd1, 32'd2000);
      add_sample(1'b1, 12'd305, 12'd300, 3'd2, 3'd0, 32'd2100);
      add_sample(1'b1, 12'd305, 12'd300, 3'd2, 3'd4, 32'd2150);
      add_sample(1'b1, 12'd305, 12'd300, 3'd0, 3'd0, 32'd2100);
      add_sample(1'b1, 12'd305, 12'd300, 3'd2, 3'd0, 32'd2500);
      add_sample(1'b1, 12'd305, 12'd300, 3'd0, 3'd0, 32'd2600);
      add_sample(1'b1, 12'd304, 12'd304, 3'd2, 3'd0, 32'd2604);
      add_sample(1'b1, 12'd304, 12'd304, 3'd0, 3'd6, 32'd2700);
      add_sample(1'b1, 12'd3000, 12'd10, 3'd4, 3'd0, 32'hFFFF_FF00);
      add_sample(1'b1, 12'd3000, 12'd10, 3'd0, 3'd0, 32'hFFFF_FF00);
      add_sample(1'b1, 12'd3000, 12'd10, 3'd4, 3'd0, 32'h0000_0040);
      add_sample(1'b1, 12'd3000, 12'd10, 3'd0, 3'd3, 32'h0000_0050);
      add_sample(1'b1, 12'd3001, 12'd11, 3'd1, 3'd7, 32'h0000_0060);
      add_sample(1'b1, 12'd3001, 12'd11, 3'd0, 3'd7, 32'h8000_0000);

      run_phase(16'hFFFF, 16'd4095, 50, 67, 0, 1'b0);
      run_phase(16'd0, 16'd0, 40, 0, 67, 1'b1);
      run_phase(16'd1000, 16'hF014, 60, 35, 35, 1'b0);
      run_phase(16'd500, 16'd5, 65, 0, 0, 1'b0);
      settle();

      if (mismatches == 0 && events_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
